/* hdl/bavs_pkg.sv */
// ----------------------------------------------------------------------------
// bavs_pkg
// Shared widths, limits and the altitude lookup table of the barometric
// altimeter.
// ----------------------------------------------------------------------------
package bavs_pkg;

  localparam int unsigned PRESS_W = 17;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned ALT_W   = 24;
  localparam int unsigned SPD_W   = 24;

  // ring depth, a power of two so the average is a shift of the sum
  localparam int unsigned AVG_DEPTH = 16;

  localparam logic [PRESS_W-1:0] BASELINE_RESET = 17'd101325;
  localparam logic [PRESS_W-1:0] RATIO_MAX      = 17'd131071;
  localparam int unsigned        TAB_N          = 257;
  localparam longint unsigned    SCALE_CM       = 64'd4433000;
  localparam longint unsigned    Q30_ONE        = 64'd1 << 30;

  typedef logic signed [ALT_W-1:0] alt_tab_t [TAB_N];

  // integer square root, one result bit per pass
  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned x;
    r = 0;
    x = v;
    for (int i = 0; i < 32; i++) begin
      b = 64'd1 << (62 - 2 * i);
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // log2 in q30 by repeated squaring
  function automatic longint unsigned log2_q30(int unsigned k);
    int unsigned     n;
    longint unsigned m;
    longint unsigned fr;
    n  = 0;
    fr = 0;
    for (int i = 0; i < 9; i++) begin
      if ((k >> (i + 1)) != 0) n = i + 1;
    end
    m = longint'(k) << (30 - n);
    for (int j = 0; j < 30; j++) begin
      m  = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (Q30_ONE << 1)) begin
        m  = m >> 1;
        fr = fr | 64'd1;
      end
    end
    return (longint'(n) << 30) | fr;
  endfunction

  // altitude in cm at ratio k/128, evaluated at elaboration
  function automatic alt_tab_t build_alt_table();
    alt_tab_t        t;
    longint unsigned roots [31];
    longint          lg;
    longint          e;
    longint unsigned ep;
    longint unsigned ip;
    longint unsigned fr;
    longint unsigned p;
    longint unsigned y;
    longint unsigned z;
    roots[0] = Q30_ONE;
    roots[1] = isqrt64(64'd2 << 60);
    for (int j = 2; j <= 30; j++) roots[j] = isqrt64(roots[j-1] << 30);
    t[0] = ALT_W'(SCALE_CM);
    for (int k = 1; k < TAB_N; k++) begin
      lg = longint'(log2_q30(k)) - (longint'(7) << 30);
      e  = lg * 1000 / 5255;
      ep = longint'(e + (longint'(2) << 30));
      ip = ep >> 30;
      fr = ep & (Q30_ONE - 1);
      p  = Q30_ONE;
      for (int j = 1; j <= 30; j++) begin
        if (((fr >> (30 - j)) & 64'd1) != 0) p = (p * roots[j]) >> 30;
      end
      y = (p << ip) >> 2;
      z = (SCALE_CM * y + (Q30_ONE >> 1)) >> 30;
      t[k] = ALT_W'(longint'(SCALE_CM) - longint'(z));
    end
    return t;
  endfunction

  localparam alt_tab_t ALT_TAB = build_alt_table();

endpackage

/* hdl/bavs_if.sv */
// ----------------------------------------------------------------------------
// bavs_in_if / bavs_out_if
// Valid/ready channels for pressure samples and altitude results.
// ----------------------------------------------------------------------------
interface bavs_in_if;
  logic                            valid;
  logic                            ready;
  logic [bavs_pkg::PRESS_W-1:0]    pressure_sample;
  logic [bavs_pkg::TIME_W-1:0]     elapsed_ms;
  modport source (output valid, pressure_sample, elapsed_ms, input ready);
  modport sink   (input valid, pressure_sample, elapsed_ms, output ready);
endinterface

interface bavs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bavs_pkg::ALT_W-1:0]  altitude_cm;
  logic signed [bavs_pkg::SPD_W-1:0]  vertical_speed;
  logic [bavs_pkg::PRESS_W-1:0]       mean_pressure;
  logic                               time_error;
  modport source (output valid, altitude_cm, vertical_speed, mean_pressure,
                  time_error, input ready);
  modport sink   (input valid, altitude_cm, vertical_speed, mean_pressure,
                  time_error, output ready);
endinterface

/* hdl/baro_altitude_vertical_speed.sv */
// ----------------------------------------------------------------------------
// baro_altitude_vertical_speed
// Moving-average barometric altimeter with vertical speed.
// ----------------------------------------------------------------------------
// in_i carries one pressure sample and the ms elapsed since the last one;
// out_o returns altitude (cm), vertical speed (cm/s, saturated), the moving
// average pressure and a flag for a zero elapsed time. cfg_we_i/cfg_wdata_i
// write the baseline pressure; write it only while no beat is in flight.
// One beat is worked at a time. The samples live in a ring memory with a
// registered read; the average is a shift of the running sum, and
// one restoring divider, one quotient bit a cycle over 36 bits, is shared by
// the ratio and the speed.
// When elapsed_ms is zero the speed division is skipped. The next input
// beat is taken the cycle after the result register loads.
// The result sits in an output register, so a stalled receiver holds only
// the finished beat; the next input is accepted meanwhile and waits for the
// register only at the end of its work. Reset clears the ring through
// per-entry valid bits at once, so no clearing pass is needed, and sets the
// baseline to 101325.
// ----------------------------------------------------------------------------
module baro_altitude_vertical_speed (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bavs_pkg::PRESS_W-1:0]   cfg_wdata_i,
  bavs_in_if.sink                        in_i,
  bavs_out_if.source                     out_o
);

  localparam int unsigned AVG_DEPTH = bavs_pkg::AVG_DEPTH;
  localparam int unsigned SLW   = $clog2(AVG_DEPTH);
  localparam int unsigned SW    = bavs_pkg::PRESS_W + $clog2(AVG_DEPTH);
  localparam int unsigned DVW   = 36;
  localparam int unsigned CNTW  = $clog2(DVW);
  localparam int unsigned PW    = bavs_pkg::PRESS_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SUM  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_INT  = 7'b0001000,
    S_DLT  = 7'b0010000,
    S_SPD  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    OP_RAT = 2'd1,
    OP_SPD = 2'd2
  } div_op_e;

  state_e  state_q, state_d;
  div_op_e op_q;

  logic [PW-1:0]                  base_q;
  logic [PW-1:0]                  ring_mem [AVG_DEPTH];
  logic [PW-1:0]                  rd_q;
  logic [AVG_DEPTH-1:0]           vld_q;
  logic                           old_vld_q;
  logic [SLW-1:0]                 slot_q;
  logic [SW-1:0]                  sum_q;
  logic [PW-1:0]                  sample_q;
  logic [bavs_pkg::TIME_W-1:0]    elapsed_q;
  logic [PW-1:0]                  avg_q;
  logic [PW-1:0]                  ratio_q;
  logic signed [bavs_pkg::ALT_W-1:0] alt_q;
  logic signed [bavs_pkg::ALT_W-1:0] last_q;
  logic                           neg_q;
  logic signed [bavs_pkg::SPD_W-1:0] spd_q;
  logic                           terr_q;

  logic [DVW-1:0]                 dvd_q;
  logic [PW-1:0]                  rem_q;
  logic [PW-1:0]                  dsr_q;
  logic [CNTW-1:0]                cnt_q;

  logic                           acc_in;
  logic                           out_free;
  logic                           out_vld_q;

  assign acc_in   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // divider step
  logic [PW:0]    div_trial;
  logic           div_bit;
  logic [PW-1:0]  div_rem;
  assign div_trial = {rem_q, dvd_q[DVW-1]};
  assign div_bit   = (div_trial >= {1'b0, dsr_q});
  assign div_rem   = div_bit ? PW'(div_trial - {1'b0, dsr_q}) : div_trial[PW-1:0];

  logic [DVW-1:0] quot;
  assign quot = {dvd_q[DVW-2:0], div_bit};

  // running sum update and average by shift
  logic [SW-1:0] sum_new;
  logic [PW-1:0] avg_new;
  assign sum_new = sum_q - (old_vld_q ? SW'(rd_q) : SW'(0)) + SW'(sample_q);
  assign avg_new = sum_new[SW-1:SLW];

  // table interpolation
  logic [8:0]                          seg;
  logic [8:0]                          frac;
  logic signed [bavs_pkg::ALT_W-1:0]   t0;
  logic signed [bavs_pkg::ALT_W-1:0]   t1;
  logic signed [bavs_pkg::ALT_W:0]     tdiff;
  logic signed [35:0]                  blend;
  logic signed [bavs_pkg::ALT_W-1:0]   alt_new;
  assign seg     = {1'b0, ratio_q[16:9]};
  assign frac    = ratio_q[8:0];
  assign t0      = bavs_pkg::ALT_TAB[seg];
  assign t1      = bavs_pkg::ALT_TAB[seg + 9'd1];
  assign tdiff   = 25'(t1) - 25'(t0);
  assign blend   = (36'(t0) <<< 9) + 36'(tdiff) * $signed({27'd0, frac}) + 36'sd256;
  assign alt_new = bavs_pkg::ALT_W'(blend >>> 9);

  // altitude change magnitude
  logic signed [bavs_pkg::ALT_W:0] dalt;
  logic [bavs_pkg::ALT_W:0]        dmag;
  assign dalt = 25'(alt_q) - 25'(last_q);
  assign dmag = dalt[bavs_pkg::ALT_W] ? 25'(-dalt) : 25'(dalt);

  // speed saturation
  logic signed [bavs_pkg::SPD_W-1:0] spd_sat;
  always_comb begin
    if (neg_q) begin
      spd_sat = (quot > DVW'(8388608)) ? -24'sd8388608 : -$signed(quot[23:0]);
    end else begin
      spd_sat = (quot > DVW'(8388607)) ? 24'sd8388607 : $signed(quot[23:0]);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (acc_in) state_d = S_SUM;
      S_SUM:   state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == '0) begin
          unique case (op_q)
            OP_RAT:  state_d = S_INT;
            OP_SPD:  state_d = S_FIN;
            default: state_d = S_FIN;
          endcase
        end
      end
      S_INT:   state_d = S_DLT;
      S_DLT:   state_d = (elapsed_q == '0) ? S_FIN : S_SPD;
      S_SPD:   state_d = S_DIV;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      base_q    <= bavs_pkg::BASELINE_RESET;
      vld_q     <= '0;
      slot_q    <= '0;
      sum_q     <= '0;
      last_q    <= '0;
      out_vld_q <= 1'b0;
      op_q      <= OP_RAT;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) base_q <= cfg_wdata_i;
      if (acc_in) begin
        vld_q[slot_q] <= 1'b1;
        slot_q <= (slot_q == SLW'(AVG_DEPTH - 1)) ? '0 : slot_q + SLW'(1);
      end
      if (state_q == S_SUM) begin
        sum_q <= sum_new;
        op_q  <= OP_RAT;
        cnt_q <= CNTW'(DVW - 1);
      end
      if (state_q == S_DIV) cnt_q <= cnt_q - CNTW'(1);
      if (state_q == S_DLT) last_q <= alt_q;
      if (state_q == S_SPD) begin
        op_q  <= OP_SPD;
        cnt_q <= CNTW'(DVW - 1);
      end
      if (state_q == S_FIN && out_free) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  // ring memory, read before write at the same slot
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      rd_q             <= ring_mem[slot_q];
      ring_mem[slot_q] <= in_i.pressure_sample;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      sample_q  <= in_i.pressure_sample;
      elapsed_q <= in_i.elapsed_ms;
      old_vld_q <= vld_q[slot_q];
    end
    unique case (state_q)
      S_SUM: begin
        avg_q <= avg_new;
        dvd_q <= DVW'({avg_new, 16'd0});
        rem_q <= '0;
        dsr_q <= base_q;
      end
      S_DIV: begin
        dvd_q <= quot;
        rem_q <= div_rem;
        if (cnt_q == '0) begin
          case (op_q)
            OP_RAT: begin
              ratio_q <= (quot > DVW'(bavs_pkg::RATIO_MAX)) ? bavs_pkg::RATIO_MAX
                                                           : quot[PW-1:0];
            end
            default: begin
              spd_q  <= spd_sat;
              terr_q <= 1'b0;
            end
          endcase
        end
      end
      S_INT: alt_q <= alt_new;
      S_DLT: begin
        neg_q <= dalt[bavs_pkg::ALT_W];
        dvd_q <= DVW'(dmag * 35'd1000);
        if (elapsed_q == '0) begin
          spd_q  <= '0;
          terr_q <= 1'b1;
        end
      end
      S_SPD: begin
        rem_q <= '0;
        dsr_q <= PW'(elapsed_q);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && out_free) begin
      out_o.altitude_cm    <= alt_q;
      out_o.vertical_speed <= spd_q;
      out_o.mean_pressure  <= avg_q;
      out_o.time_error     <= terr_q;
    end
  end

  assign out_o.valid = out_vld_q;

endmodule

/* hdl/bavs_checker.sv */
// ----------------------------------------------------------------------------
// bavs_checker
// Port-level checks of the altimeter, bound to the top level.
// ----------------------------------------------------------------------------
module bavs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] out_alt_i,
  input logic [23:0] out_spd_i,
  input logic        out_terr_i
);

  // a stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_alt_i)
      && $stable(out_spd_i) && $stable(out_terr_i))
    else $error("stalled result beat changed");

  // one beat in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while busy");

  // zero elapsed time forces zero speed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_terr_i |-> out_spd_i == 24'd0)
    else $error("time error with nonzero speed");

endmodule

bind baro_altitude_vertical_speed bavs_checker u_bavs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_alt_i   (out_o.altitude_cm),
  .out_spd_i   (out_o.vertical_speed),
  .out_terr_i  (out_o.time_error)
);
